>>> src/ffha_pkg.sv
`default_nettype none
package ffha_pkg;

    localparam int ADDR_BITS         = 16;
    localparam int FREE_SLOTS        = 32;
    localparam int BLOCK_SLOTS       = 32;
    localparam int HEADER_BYTES      = 16;
    localparam int NODE_BYTES        = 16;
    localparam int PAGE_HEADER_BYTES = 8;
    localparam int HEAP_RESET        = 4096;
    localparam int ALIGN_MAX         = 256;

    localparam int FIDX_W = $clog2(FREE_SLOTS);
    localparam int BIDX_W = $clog2(BLOCK_SLOTS);
    localparam int CNT_W  = 6;
    localparam int PAD_W  = 9;

    localparam int DIV_W     = 17;
    localparam int DIV_STEP  = 4;
    localparam int DIV_STEPS = (DIV_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_SH_W  = DIV_STEPS * DIV_STEP;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        S_OK      = 2'd0,
        S_NOFIT   = 2'd1,
        S_FULL    = 2'd2,
        S_UNKNOWN = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_A_REQDIV,
        ST_A_REQWAIT,
        ST_A_RD,
        ST_A_DAT,
        ST_A_WAIT,
        ST_RM_RD,
        ST_RM_WR,
        ST_F_RD,
        ST_F_CHK,
        ST_P_RD,
        ST_P_CHK,
        ST_MERGE,
        ST_SU_RD,
        ST_SU_WR,
        ST_COMMIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] size;
    } t_free_ent;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] size;
        logic [PAD_W-1:0]     pad;
    } t_blk_ent;

endpackage
`default_nettype wire

>>> src/first_fit_heap_allocator.sv
// First-fit heap allocator: one heap page kept as an address-sorted table of
// free segments, plus a table of live grants.
// Input stream: s_tuser is the command (allocate or free); s_tdata carries
// the request size, alignment and the address of a block to free.
// Output stream: one item per input item; m_tuser is the status, m_tdata the
// granted address and size with the usage counters after the command.
// APB register 0 (heap_size) rebuilds the heap empty; write it only when idle.
// An allocate first takes the remainder of the request size by the alignment,
// then walks the free segments in order, each waiting on a remainder by the
// alignment, and moves the later entries down when a segment is removed.
// A free scans the grant table for the address, skipping empty entries, then
// walks the free table to find its neighbours and may move entries.
// The free table and the grant table each sit in a single-port-read memory,
// so a walk reads one entry at a time.
// Reset: heap_size is 4096 and the heap holds one free segment; a table
// set-up state follows reset and every heap_size write.
// A stalled output holds its item in an output register; the next input item
// is still taken and worked, and waits to load until the register drains.
`default_nettype none
module first_fit_heap_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] req_size, [24:16] align, [40:25] address, [47:41] zero
    input  wire logic [47:0] s_tdata,
    // [0] command
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] data_address, [31:16] granted_bytes, [47:32] used_bytes,
    // [63:48] free_bytes, [69:64] live_allocations, [71:70] zero
    output logic [71:0]      m_tdata,
    // [1:0] status
    output logic [1:0]       m_tuser
);

    localparam int AB = ffha_pkg::ADDR_BITS;
    localparam int FW = ffha_pkg::FIDX_W;
    localparam int BW = ffha_pkg::BIDX_W;
    localparam int CW = ffha_pkg::CNT_W;
    localparam int PW = ffha_pkg::PAD_W;

    ffha_pkg::t_state  r_state, n_state;
    ffha_pkg::t_status r_stat, n_stat;

    logic [AB-1:0]               r_heap, n_heap;
    logic [CW-1:0]               r_count, n_count;
    logic [AB-1:0]               r_used, n_used;
    logic [CW-1:0]               r_live, n_live;
    logic [AB-1:0]               r_ftot, n_ftot;
    logic [ffha_pkg::BLOCK_SLOTS-1:0] r_valid, n_valid;
    logic                        r_cmd, n_cmd;
    logic [AB-1:0]               r_req, n_req;
    logic [PW-1:0]               r_a, n_a;
    logic [AB-1:0]               r_addr, n_addr;
    logic [BW-1:0]               r_slot, n_slot;
    logic [AB:0]                 r_rsize, n_rsize;
    logic [CW-1:0]               r_idx, n_idx;
    logic [CW-1:0]               r_j, n_j;
    logic [CW-1:0]               r_k, n_k;
    logic [AB-1:0]               r_s, n_s;
    logic [AB-1:0]               r_fs, n_fs;
    logic [AB-1:0]               r_seg, n_seg;
    logic [AB-1:0]               r_gsize, n_gsize;
    logic [AB-1:0]               r_daddr, n_daddr;
    ffha_pkg::t_free_ent         r_prev, n_prev;
    ffha_pkg::t_free_ent         r_next, n_next;
    logic                        r_hnext, n_hnext;
    logic                        r_ovalid, n_ovalid;
    logic [71:0]                 r_odata, n_odata;
    logic [1:0]                  r_ouser, n_ouser;

    logic                        fm_we, fm_re;
    logic [FW-1:0]               fm_waddr, fm_raddr;
    ffha_pkg::t_free_ent         fm_wdata, fm_rdata;
    logic                        bm_we, bm_re;
    logic [BW-1:0]               bm_waddr, bm_raddr;
    ffha_pkg::t_blk_ent          bm_wdata, bm_rdata;

    logic                        div_start, div_done;
    logic [ffha_pkg::DIV_W-1:0]  div_dvd;
    logic [PW-1:0]               div_rem;

    logic                        cfg_we;
    logic                        slot_found;
    logic [BW-1:0]               free_slot;
    logic [PW-1:0]               a_in;
    logic [PW-1:0]               adj_c;
    logic [PW-1:0]               pad_c;
    logic [AB+1:0]               total_c;
    logic [AB-1:0]               left_c;
    logic [CW-1:0]               j_inc, j_dec, idx_dec;
    logic                        mp_c, mn_c;
    logic [AB-1:0]               ok_daddr, ok_gsize;

    ffha_ram #(.W($bits(ffha_pkg::t_free_ent)), .D(ffha_pkg::FREE_SLOTS)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (fm_we),
        .i_waddr (fm_waddr),
        .i_wdata (fm_wdata),
        .i_re    (fm_re),
        .i_raddr (fm_raddr),
        .o_rdata (fm_rdata)
    );

    ffha_ram #(.W($bits(ffha_pkg::t_blk_ent)), .D(ffha_pkg::BLOCK_SLOTS)) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_re    (bm_re),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    ffha_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_a),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign cfg_we   = psel & penable & pwrite & pready & (paddr[2] == 1'b0);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {16'd0, r_heap} : 32'd0;
    assign s_tready = (r_state == ffha_pkg::ST_IDLE);
    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_odata;
    assign m_tuser  = r_ouser;

    assign a_in    = s_tdata[24:16];
    assign adj_c   = (div_rem != '0) ? (r_a - div_rem) : '0;
    assign pad_c   = PW'(ffha_pkg::HEADER_BYTES) + adj_c;
    assign total_c = {1'b0, r_rsize} + (AB+2)'(pad_c);
    assign left_c  = r_fs - total_c[AB-1:0];
    assign j_inc   = r_j + 1'b1;
    assign j_dec   = r_j - 1'b1;
    assign idx_dec = r_idx - 1'b1;
    assign mp_c    = (r_idx != '0) &&
                     (({1'b0, r_prev.start} + {1'b0, r_prev.size}) == {1'b0, r_seg});
    assign mn_c    = r_hnext && (({1'b0, r_seg} + {1'b0, r_gsize}) == {1'b0, r_next.start});
    assign ok_daddr = (r_stat == ffha_pkg::S_OK && r_cmd == ffha_pkg::CMD_ALLOC) ? r_daddr : '0;
    assign ok_gsize = (r_stat == ffha_pkg::S_OK) ? r_gsize : '0;

    always_comb begin
        slot_found = 1'b0;
        free_slot  = '0;
        for (int i = ffha_pkg::BLOCK_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                slot_found = 1'b1;
                free_slot  = BW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_stat   = r_stat;
        n_heap   = r_heap;
        n_count  = r_count;
        n_used   = r_used;
        n_live   = r_live;
        n_ftot   = r_ftot;
        n_valid  = r_valid;
        n_cmd    = r_cmd;
        n_req    = r_req;
        n_a      = r_a;
        n_addr   = r_addr;
        n_slot   = r_slot;
        n_rsize  = r_rsize;
        n_idx    = r_idx;
        n_j      = r_j;
        n_k      = r_k;
        n_s      = r_s;
        n_fs     = r_fs;
        n_seg    = r_seg;
        n_gsize  = r_gsize;
        n_daddr  = r_daddr;
        n_prev   = r_prev;
        n_next   = r_next;
        n_hnext  = r_hnext;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        n_ouser  = r_ouser;
        fm_we    = 1'b0;
        fm_waddr = '0;
        fm_wdata = '0;
        fm_re    = 1'b0;
        fm_raddr = '0;
        bm_we    = 1'b0;
        bm_waddr = '0;
        bm_wdata = '0;
        bm_re    = 1'b0;
        bm_raddr = '0;
        div_start = 1'b0;
        div_dvd   = '0;

        if (r_ovalid && m_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ffha_pkg::ST_INIT: begin
                fm_we    = 1'b1;
                fm_waddr = '0;
                fm_wdata.start = AB'(ffha_pkg::PAGE_HEADER_BYTES);
                fm_wdata.size  = r_heap - AB'(ffha_pkg::PAGE_HEADER_BYTES);
                n_state  = ffha_pkg::ST_IDLE;
            end
            ffha_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    n_cmd   = s_tuser;
                    n_req   = s_tdata[15:0];
                    n_addr  = s_tdata[40:25];
                    n_a     = (a_in == '0) ? PW'(1) :
                              (a_in > PW'(ffha_pkg::ALIGN_MAX)) ? PW'(ffha_pkg::ALIGN_MAX) : a_in;
                    n_slot  = free_slot;
                    n_k     = '0;
                    n_idx   = '0;
                    n_hnext = 1'b0;
                    if (s_tuser == ffha_pkg::CMD_FREE) begin
                        n_state = ffha_pkg::ST_F_RD;
                    end else if (!slot_found) begin
                        n_stat  = ffha_pkg::S_FULL;
                        n_state = ffha_pkg::ST_DONE;
                    end else begin
                        n_state = ffha_pkg::ST_A_REQDIV;
                    end
                end
            end
            ffha_pkg::ST_A_REQDIV: begin
                div_start = 1'b1;
                div_dvd   = {1'b0, r_req};
                n_state   = ffha_pkg::ST_A_REQWAIT;
            end
            ffha_pkg::ST_A_REQWAIT: begin
                if (div_done) begin
                    n_rsize = {1'b0, r_req} + (AB+1)'(adj_c);
                    n_state = ffha_pkg::ST_A_RD;
                end
            end
            ffha_pkg::ST_A_RD: begin
                if (r_idx == r_count) begin
                    n_stat  = ffha_pkg::S_NOFIT;
                    n_state = ffha_pkg::ST_DONE;
                end else begin
                    fm_re    = 1'b1;
                    fm_raddr = r_idx[FW-1:0];
                    n_state  = ffha_pkg::ST_A_DAT;
                end
            end
            ffha_pkg::ST_A_DAT: begin
                n_s       = fm_rdata.start;
                n_fs      = fm_rdata.size;
                div_start = 1'b1;
                div_dvd   = {1'b0, fm_rdata.start} + ffha_pkg::DIV_W'(ffha_pkg::HEADER_BYTES);
                n_state   = ffha_pkg::ST_A_WAIT;
            end
            ffha_pkg::ST_A_WAIT: begin
                if (div_done) begin
                    if ({2'b00, r_fs} >= total_c) begin
                        n_daddr       = r_s + AB'(pad_c);
                        bm_we         = 1'b1;
                        bm_waddr      = r_slot;
                        bm_wdata.addr = r_s + AB'(pad_c);
                        bm_wdata.pad  = pad_c;
                        if (left_c > AB'(ffha_pkg::NODE_BYTES)) begin
                            fm_we          = 1'b1;
                            fm_waddr       = r_idx[FW-1:0];
                            fm_wdata.start = r_s + total_c[AB-1:0];
                            fm_wdata.size  = left_c;
                            bm_wdata.size  = total_c[AB-1:0];
                            n_gsize        = total_c[AB-1:0];
                            n_state        = ffha_pkg::ST_COMMIT;
                        end else begin
                            bm_wdata.size = r_fs;
                            n_gsize       = r_fs;
                            n_j           = r_idx;
                            n_state       = ffha_pkg::ST_RM_RD;
                        end
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ffha_pkg::ST_A_RD;
                    end
                end
            end
            ffha_pkg::ST_RM_RD: begin
                if (j_inc < r_count) begin
                    fm_re    = 1'b1;
                    fm_raddr = j_inc[FW-1:0];
                    n_state  = ffha_pkg::ST_RM_WR;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = ffha_pkg::ST_COMMIT;
                end
            end
            ffha_pkg::ST_RM_WR: begin
                fm_we    = 1'b1;
                fm_waddr = r_j[FW-1:0];
                fm_wdata = fm_rdata;
                n_j      = j_inc;
                n_state  = ffha_pkg::ST_RM_RD;
            end
            ffha_pkg::ST_F_RD: begin
                if (r_k == CW'(ffha_pkg::BLOCK_SLOTS)) begin
                    n_stat  = ffha_pkg::S_UNKNOWN;
                    n_state = ffha_pkg::ST_DONE;
                end else if (!r_valid[r_k[BW-1:0]]) begin
                    n_k = r_k + 1'b1;
                end else begin
                    bm_re    = 1'b1;
                    bm_raddr = r_k[BW-1:0];
                    n_state  = ffha_pkg::ST_F_CHK;
                end
            end
            ffha_pkg::ST_F_CHK: begin
                if (bm_rdata.addr == r_addr) begin
                    n_seg   = r_addr - AB'(bm_rdata.pad);
                    n_gsize = bm_rdata.size;
                    n_idx   = '0;
                    n_state = ffha_pkg::ST_P_RD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ffha_pkg::ST_F_RD;
                end
            end
            ffha_pkg::ST_P_RD: begin
                if (r_idx == r_count) begin
                    n_state = ffha_pkg::ST_MERGE;
                end else begin
                    fm_re    = 1'b1;
                    fm_raddr = r_idx[FW-1:0];
                    n_state  = ffha_pkg::ST_P_CHK;
                end
            end
            ffha_pkg::ST_P_CHK: begin
                if (fm_rdata.start <= r_seg) begin
                    n_prev  = fm_rdata;
                    n_idx   = r_idx + 1'b1;
                    n_state = ffha_pkg::ST_P_RD;
                end else begin
                    n_next  = fm_rdata;
                    n_hnext = 1'b1;
                    n_state = ffha_pkg::ST_MERGE;
                end
            end
            ffha_pkg::ST_MERGE: begin
                priority if (mp_c && mn_c) begin
                    fm_we          = 1'b1;
                    fm_waddr       = idx_dec[FW-1:0];
                    fm_wdata.start = r_prev.start;
                    fm_wdata.size  = r_prev.size + r_gsize + r_next.size;
                    n_j            = r_idx;
                    n_state        = ffha_pkg::ST_RM_RD;
                end else if (mp_c) begin
                    fm_we          = 1'b1;
                    fm_waddr       = idx_dec[FW-1:0];
                    fm_wdata.start = r_prev.start;
                    fm_wdata.size  = r_prev.size + r_gsize;
                    n_state        = ffha_pkg::ST_COMMIT;
                end else if (mn_c) begin
                    fm_we          = 1'b1;
                    fm_waddr       = r_idx[FW-1:0];
                    fm_wdata.start = r_seg;
                    fm_wdata.size  = r_next.size + r_gsize;
                    n_state        = ffha_pkg::ST_COMMIT;
                end else if (r_count == CW'(ffha_pkg::FREE_SLOTS)) begin
                    n_stat  = ffha_pkg::S_FULL;
                    n_state = ffha_pkg::ST_DONE;
                end else begin
                    n_j     = r_count;
                    n_state = ffha_pkg::ST_SU_RD;
                end
            end
            ffha_pkg::ST_SU_RD: begin
                if (r_j > r_idx) begin
                    fm_re    = 1'b1;
                    fm_raddr = j_dec[FW-1:0];
                    n_state  = ffha_pkg::ST_SU_WR;
                end else begin
                    fm_we          = 1'b1;
                    fm_waddr       = r_idx[FW-1:0];
                    fm_wdata.start = r_seg;
                    fm_wdata.size  = r_gsize;
                    n_count        = r_count + 1'b1;
                    n_state        = ffha_pkg::ST_COMMIT;
                end
            end
            ffha_pkg::ST_SU_WR: begin
                fm_we    = 1'b1;
                fm_waddr = r_j[FW-1:0];
                fm_wdata = fm_rdata;
                n_j      = j_dec;
                n_state  = ffha_pkg::ST_SU_RD;
            end
            ffha_pkg::ST_COMMIT: begin
                if (r_cmd == ffha_pkg::CMD_ALLOC) begin
                    n_valid[r_slot] = 1'b1;
                    n_used = r_used + r_gsize;
                    n_live = r_live + 1'b1;
                    n_ftot = r_ftot - r_gsize;
                end else begin
                    n_valid[r_k[BW-1:0]] = 1'b0;
                    n_used = r_used - r_gsize;
                    n_live = r_live - 1'b1;
                    n_ftot = r_ftot + r_gsize;
                end
                n_stat  = ffha_pkg::S_OK;
                n_state = ffha_pkg::ST_DONE;
            end
            ffha_pkg::ST_DONE: begin
                if (!r_ovalid || m_tready) begin
                    n_ovalid = 1'b1;
                    n_ouser  = r_stat;
                    n_odata  = {2'b00, r_live, r_ftot, r_used, ok_gsize, ok_daddr};
                    n_state  = ffha_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ffha_pkg::ST_INIT;
            end
        endcase

        if (cfg_we) begin
            n_heap  = pwdata[AB-1:0];
            n_valid = '0;
            n_used  = '0;
            n_live  = '0;
            if (pwdata[AB-1:0] > AB'(ffha_pkg::PAGE_HEADER_BYTES)) begin
                n_count = CW'(1);
                n_ftot  = pwdata[AB-1:0] - AB'(ffha_pkg::PAGE_HEADER_BYTES);
            end else begin
                n_count = '0;
                n_ftot  = '0;
            end
            n_state = ffha_pkg::ST_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat   <= ffha_pkg::S_OK;
            r_heap   <= AB'(ffha_pkg::HEAP_RESET);
            r_count  <= CW'(1);
            r_used   <= '0;
            r_live   <= '0;
            r_ftot   <= AB'(ffha_pkg::HEAP_RESET - ffha_pkg::PAGE_HEADER_BYTES);
            r_valid  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_stat   <= n_stat;
            r_heap   <= n_heap;
            r_count  <= n_count;
            r_used   <= n_used;
            r_live   <= n_live;
            r_ftot   <= n_ftot;
            r_valid  <= n_valid;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_req   <= n_req;
        r_a     <= n_a;
        r_addr  <= n_addr;
        r_slot  <= n_slot;
        r_rsize <= n_rsize;
        r_idx   <= n_idx;
        r_j     <= n_j;
        r_k     <= n_k;
        r_s     <= n_s;
        r_fs    <= n_fs;
        r_seg   <= n_seg;
        r_gsize <= n_gsize;
        r_daddr <= n_daddr;
        r_prev  <= n_prev;
        r_next  <= n_next;
        r_hnext <= n_hnext;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ffha_pkg::FREE_SLOTS))
        else $error("free segment count out of range");

    a_live_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live == CW'($countones(r_valid)))
        else $error("live count disagrees with grant table");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ffha_pkg::ST_A_REQWAIT || r_state == ffha_pkg::ST_A_WAIT))
        else $error("remainder finished outside a wait state");
`endif

endmodule
`default_nettype wire

>>> src/ffha_ram.sv
`default_nettype none
module ffha_ram #(
    parameter int W = 32,
    parameter int D = 32,
    localparam int AW = $clog2(D)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> src/ffha_rem.sv
`default_nettype none
module ffha_rem (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [ffha_pkg::DIV_W-1:0]      i_dividend,
    input  wire logic [ffha_pkg::PAD_W-1:0]      i_divisor,
    output logic                                 o_done,
    output logic      [ffha_pkg::PAD_W-1:0]      o_rem
);

    logic                                r_busy;
    logic                                r_done;
    logic [$clog2(ffha_pkg::DIV_STEPS):0] r_cnt;
    logic [ffha_pkg::DIV_SH_W-1:0]       r_sh;
    logic [ffha_pkg::PAD_W-1:0]          r_rem;
    logic [ffha_pkg::PAD_W-1:0]          r_div;
    logic [ffha_pkg::PAD_W-1:0]          n_rem;
    logic [ffha_pkg::PAD_W:0]            x;

    always_comb begin
        n_rem = r_rem;
        x     = '0;
        for (int i = 0; i < ffha_pkg::DIV_STEP; i++) begin
            x = {n_rem, r_sh[ffha_pkg::DIV_SH_W-1-i]};
            if (x >= {1'b0, r_div}) begin
                x = x - {1'b0, r_div};
            end
            n_rem = x[ffha_pkg::PAD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($bits(r_cnt))'(ffha_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= ffha_pkg::DIV_SH_W'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_sh  <= r_sh << ffha_pkg::DIV_STEP;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire
